// ===== rtl/tpp_pkg.sv =====
// shared constants, payload types and controller/datapath link types for the playback pacer
`default_nettype none

package tpp_pkg;

  localparam int TIME_BITS       = 48;
  localparam int COUNT_BITS      = 32;
  localparam int SPEED_FRAC_BITS = 8;
  localparam int SPEED_BITS      = 16;
  localparam int RES_BITS        = 20;
  localparam int CFG_DATA_BITS   = 20;
  localparam int CFG_INDEX_BITS  = 2;

  // microseconds per millisecond and the width of a remainder below it
  localparam int DIVISOR  = 1000;
  localparam int REM_BITS = 10;

  // a millisecond count of a full time value fits in TIME_BITS - 9 bits
  localparam int MS_BITS = TIME_BITS - 9;

  // divide-by-1000 works on one byte-wide digit of the dividend per step
  localparam int DIGIT_BITS   = 8;
  localparam int DIV_ITERS    = (TIME_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int DIV_WIDTH    = DIV_ITERS * DIGIT_BITS;
  localparam int DIV_CNT_BITS = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

  typedef struct packed {
    logic                 kind;
    logic [TIME_BITS-1:0] record_time;
    logic [TIME_BITS-1:0] current_time;
    logic [TIME_BITS-1:0] pause_length;
  } item_t;

  typedef struct packed {
    logic                        wait_needed;
    logic [TIME_BITS-1:0]        wake_time;
    logic signed [TIME_BITS-1:0] lag_amount;
    logic                        lag_started;
    logic                        recovered;
    logic [COUNT_BITS-1:0]       recovered_count;
  } result_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mul_step;
    logic scale_step;
    logic target_step;
    logic commit;
    logic load_zero;
  } cmd_t;

  typedef struct packed {
    logic needs_target;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/tpp_ctrl.sv =====
// sequencing state machine of the playback pacer
`default_nettype none

module tpp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  output logic                 result_valid,
  input  wire logic            result_stall,
  input  wire tpp_pkg::status_t status,
  output tpp_pkg::cmd_t        cmd
);

  localparam int CB = tpp_pkg::DIV_CNT_BITS;
  localparam logic [CB-1:0] DIV_LAST = CB'(tpp_pkg::DIV_ITERS - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ZERO   = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_MUL    = 7'b0001000,
    S_SCALE  = 7'b0010000,
    S_TARGET = 7'b0100000,
    S_LAG    = 7'b1000000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CB-1:0] div_cnt;
  logic          out_free;

  assign item_stall = rst || (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.accept = item_valid && !item_stall;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          state_next = status.needs_target ? S_DIV : S_ZERO;
        end
      end
      S_ZERO: begin
        if (out_free) begin
          cmd.load_zero = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        state_next   = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_step = 1'b1;
        state_next     = S_TARGET;
      end
      S_TARGET: begin
        cmd.target_step = 1'b1;
        state_next      = S_LAG;
      end
      S_LAG: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.load_zero || cmd.commit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tpp_datapath.sv =====
// registers, divide-by-1000, scaling multiplier and lag logic of the playback pacer
`default_nettype none

module tpp_datapath #(
  parameter int SPEED_FRAC_BITS = tpp_pkg::SPEED_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [tpp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [tpp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire tpp_pkg::item_t                      item,
  input  wire tpp_pkg::cmd_t                       cmd,
  output tpp_pkg::status_t                         status,
  output tpp_pkg::result_t                         result
);

  localparam int TB    = tpp_pkg::TIME_BITS;
  localparam int CNT_B = tpp_pkg::COUNT_BITS;
  localparam int SB    = tpp_pkg::SPEED_BITS;
  localparam int RESB  = tpp_pkg::RES_BITS;
  localparam int RB    = tpp_pkg::REM_BITS;
  localparam int MSB_W = tpp_pkg::MS_BITS;
  localparam int DW    = tpp_pkg::DIV_WIDTH;
  localparam int DG    = tpp_pkg::DIGIT_BITS;
  localparam int PROD_BITS = MSB_W + SB;
  localparam int OFF_BITS  = PROD_BITS + 10;

  localparam logic [TB-1:0]    TMAX      = {TB{1'b1}};
  localparam logic [CNT_B-1:0] CMAX      = {CNT_B{1'b1}};
  localparam logic [RB:0]      DIV_CONST = (RB + 1)'(tpp_pkg::DIVISOR);

  localparam logic [tpp_pkg::CFG_INDEX_BITS-1:0] REG_SLOWDOWN = 2'd0;
  localparam logic [tpp_pkg::CFG_INDEX_BITS-1:0] REG_QUIET    = 2'd1;
  localparam logic [tpp_pkg::CFG_INDEX_BITS-1:0] REG_RES      = 2'd2;

  // configuration
  logic [SB-1:0]   slowdown_factor;
  logic            quiet_mode;
  logic [RESB-1:0] sleep_resolution;

  // pacing state
  logic             started;
  logic [TB-1:0]    first_record_time;
  logic [TB-1:0]    last_record_time;
  logic [TB-1:0]    start_clock;
  logic             lagging;
  logic [CNT_B-1:0] lag_count;

  // per-item working registers
  logic [TB-1:0]        rec_q;
  logic [TB-1:0]        now_q;
  logic [DW-1:0]        div_q;
  logic [RB-1:0]        rem_q;
  logic [PROD_BITS-1:0] prod_q;
  logic [TB-1:0]        off_q;
  logic [TB-1:0]        target_q;

  logic [TB:0]          pause_sum;
  logic [TB-1:0]        pause_sat;
  logic [TB-1:0]        elapsed;
  logic [RB-1:0]        rem_w;
  logic [RB:0]          trial;
  logic [DG-1:0]        quo;
  logic [PROD_BITS-1:0] prod_w;
  logic [PROD_BITS-1:0] scaled;
  logic [OFF_BITS-1:0]  off_w;
  logic [TB-1:0]        off_sat;
  logic [TB:0]          target_sum;
  logic [TB-1:0]        target_sat;
  logic signed [TB:0]   lag_w;
  logic signed [TB:0]   res_s;
  logic [TB-1:0]        lag_sat;
  logic                 over;
  logic                 under;
  tpp_pkg::result_t     full;
  logic                 lagging_next;
  logic [CNT_B-1:0]     count_next;

  assign status.needs_target = !item.kind && started && (item.record_time > last_record_time);

  assign pause_sum = {1'b0, start_clock} + {1'b0, item.pause_length};
  assign pause_sat = pause_sum[TB] ? TMAX : pause_sum[TB-1:0];
  assign elapsed   = item.record_time - first_record_time;

  // restoring divide by 1000, one digit of the dividend per step, msb first
  always_comb begin
    rem_w = rem_q;
    trial = '0;
    quo   = '0;
    for (int i = 0; i < DG; i++) begin
      trial = {rem_w, div_q[DW-1-i]};
      if (trial >= DIV_CONST) begin
        rem_w       = RB'(trial - DIV_CONST);
        quo[DG-1-i] = 1'b1;
      end else begin
        rem_w = trial[RB-1:0];
      end
    end
  end

  assign prod_w = PROD_BITS'(div_q[MSB_W-1:0]) * PROD_BITS'(slowdown_factor);
  assign scaled = prod_q >> SPEED_FRAC_BITS;

  // x * 1000 = x * 1024 - x * 16 - x * 8
  assign off_w   = (OFF_BITS'(scaled) << 10) - (OFF_BITS'(scaled) << 4) - (OFF_BITS'(scaled) << 3);
  assign off_sat = (off_w > OFF_BITS'(TMAX)) ? TMAX : off_w[TB-1:0];

  assign target_sum = {1'b0, start_clock} + {1'b0, off_q};
  assign target_sat = target_sum[TB] ? TMAX : target_sum[TB-1:0];

  assign lag_w = $signed({1'b0, now_q}) - $signed({1'b0, target_q});
  assign res_s = $signed({{(TB + 1 - RESB){1'b0}}, sleep_resolution});
  assign over  = lag_w > res_s;
  assign under = lag_w < -res_s;

  always_comb begin
    if (lag_w[TB] != lag_w[TB-1]) begin
      lag_sat = lag_w[TB] ? {1'b1, {(TB - 1){1'b0}}} : {1'b0, {(TB - 1){1'b1}}};
    end else begin
      lag_sat = lag_w[TB-1:0];
    end
  end

  always_comb begin
    full            = '0;
    full.wake_time  = target_q;
    full.lag_amount = lag_sat;
    lagging_next    = lagging;
    count_next      = lag_count;
    if (!quiet_mode && over) begin
      if (!lagging) begin
        lagging_next     = 1'b1;
        full.lag_started = 1'b1;
      end
      if (lag_count != CMAX) begin
        count_next = lag_count + 1'b1;
      end
    end else begin
      if (!quiet_mode && lagging) begin
        lagging_next         = 1'b0;
        full.recovered       = 1'b1;
        full.recovered_count = lag_count;
        count_next           = '0;
      end
      full.wait_needed = under;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slowdown_factor  <= SB'(256);
      quiet_mode       <= 1'b0;
      sleep_resolution <= RESB'(10000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOWDOWN: slowdown_factor  <= cfg_data[SB-1:0];
        REG_QUIET:    quiet_mode       <= cfg_data[0];
        REG_RES:      sleep_resolution <= cfg_data[RESB-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started           <= 1'b0;
      first_record_time <= '0;
      last_record_time  <= '0;
      start_clock       <= '0;
      lagging           <= 1'b0;
      lag_count         <= '0;
    end else begin
      if (cmd.accept) begin
        if (item.kind) begin
          if (started) begin
            start_clock <= pause_sat;
          end
        end else if (!started) begin
          started           <= 1'b1;
          first_record_time <= item.record_time;
          last_record_time  <= item.record_time;
          start_clock       <= item.current_time;
        end
      end
      if (cmd.commit) begin
        lagging          <= lagging_next;
        lag_count        <= count_next;
        last_record_time <= rec_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rec_q <= item.record_time;
      now_q <= item.current_time;
      div_q <= DW'(elapsed);
      rem_q <= '0;
    end
    if (cmd.div_step) begin
      div_q <= {div_q[DW-DG-1:0], quo};
      rem_q <= rem_w;
    end
    if (cmd.mul_step) begin
      prod_q <= prod_w;
    end
    if (cmd.scale_step) begin
      off_q <= off_sat;
    end
    if (cmd.target_step) begin
      target_q <= target_sat;
    end
    if (cmd.load_zero) begin
      result <= '0;
    end else if (cmd.commit) begin
      result <= full;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/timestamp_playback_pacer_unit.sv =====
// top level of the timestamp playback pacer
`default_nettype none

// Paces replay of timestamped records against a local microsecond clock. The
// first record fixes the playback origin; each later record with a newer
// timestamp gets a wake time (origin plus elapsed record time in whole
// milliseconds scaled by the Q8.8 slowdown factor), the signed lag of the
// current time behind it, a wait request when it is early by more than the
// sleep resolution, and lag start / recovery flags with a saturating count of
// late records. Pause words push the origin later; pause, first and stale
// records give an all-zero result. Every input word gives exactly one result
// word. A record that needs a wake time is taken, divided by 1000 (a restoring
// divider retiring 8 dividend bits a cycle over the 48-bit elapsed time), then
// carried through the speed multiply, the times-1000 scaling, the origin add
// and the lag compare that writes the output register, while the input stays
// closed. Pause, first and stale words write an all-zero result after being
// taken. The output register holds a finished word while the next input word
// is taken and worked on; a stalled result only holds the block when the
// following result is ready to be written.

module timestamp_playback_pacer_unit #(
  parameter int SPEED_FRAC_BITS = tpp_pkg::SPEED_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration writes
  input  wire logic                                cfg_we,
  input  wire logic [tpp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [tpp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input words
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire tpp_pkg::item_t                      item,
  // result words
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output tpp_pkg::result_t                         result
);

  tpp_pkg::cmd_t    cmd;
  tpp_pkg::status_t status;

  // sequencer: one word in flight, output register handshake
  tpp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // arithmetic, pacing state and configuration registers
  tpp_datapath #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

  // a taken word closes the input in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("input taken on consecutive cycles");

  // a recovery always reports a nonzero count and nothing else does
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.recovered == (result.recovered_count != '0)))
    else $error("recovery flag and count disagree");

  // a record cannot both start and end a lag
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.lag_started && result.recovered))
    else $error("lag start and recovery on one record");

  // a wait is only requested for an early record
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.wait_needed) |-> result.lag_amount[tpp_pkg::TIME_BITS-1])
    else $error("wait requested with non-negative lag");

endmodule

`default_nettype wire
